@@ hdl/owmb_pkg.sv @@
// ---------------------------------------------------------------------------
// owmb_pkg
// Shared widths, types, register indexes and helper functions of the
// omni-wheel mixer and bridge drive.
// ---------------------------------------------------------------------------
`default_nettype none

package owmb_pkg;

	localparam int VEL_W    = 9;   // velocity command width
	localparam int WHEEL_W  = 11;  // raw mixed wheel speed
	localparam int MAG_W    = 10;  // magnitude of a raw wheel speed
	localparam int NUM_W    = 18;  // magnitude times full duty
	localparam int QUO_W    = 8;   // normalized magnitude
	localparam int SPEED_W  = 9;   // normalized signed wheel speed
	localparam int DUTY_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int WHEELS   = 4;

	localparam logic [DUTY_W-1:0] DUTY_FULL  = 8'd255;
	localparam logic [MAG_W-1:0]  NORM_LIMIT = 10'd255;

	localparam logic [CFG_IDX_W-1:0] REG_DECAY_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 1'b1;

	// wheel lane order
	localparam int FL = 0;
	localparam int FR = 1;
	localparam int RR = 2;
	localparam int RL = 3;

	typedef logic signed [VEL_W-1:0]   vel_t;
	typedef logic signed [WHEEL_W-1:0] wheel_t;
	typedef logic signed [SPEED_W-1:0] speed_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [1:0]       q;
	} div_step_t;

	typedef struct packed {
		logic [DUTY_W-1:0] dir;
		logic [DUTY_W-1:0] pwm;
	} duty_t;

	// Two restoring division steps, quotient bits sh and sh-1.
	function automatic div_step_t div_step2(
		input logic [NUM_W-1:0] rem,
		input logic [MAG_W-1:0] den,
		input int unsigned      sh
	);
		logic [NUM_W-1:0] d_hi;
		logic [NUM_W-1:0] d_lo;
		div_step_t        o;
		d_hi = NUM_W'(den) << sh;
		d_lo = NUM_W'(den) << (sh - 1);
		o.rem = rem;
		o.q   = 2'b00;
		if (o.rem >= d_hi) begin
			o.rem  = o.rem - d_hi;
			o.q[1] = 1'b1;
		end
		if (o.rem >= d_lo) begin
			o.rem  = o.rem - d_lo;
			o.q[0] = 1'b1;
		end
		return o;
	endfunction

	// Clamp to the speed limit and map to the two bridge channel duties.
	function automatic duty_t bridge_map(
		input speed_t            s,
		input logic [DUTY_W-1:0] lim,
		input logic              slow
	);
		logic              neg;
		logic [DUTY_W-1:0] mag_s;
		logic [DUTY_W-1:0] a;
		duty_t             o;
		neg   = s[SPEED_W-1];
		mag_s = neg ? DUTY_W'(-s) : s[DUTY_W-1:0];
		a     = (mag_s > lim) ? lim : mag_s;
		if (a == '0) begin
			o.dir = '0;
			o.pwm = '0;
		end else if (!slow) begin
			o.dir = neg ? '0 : a;
			o.pwm = neg ? a : '0;
		end else begin
			o.dir = neg ? DUTY_FULL - a : DUTY_FULL;
			o.pwm = neg ? DUTY_FULL : DUTY_FULL - a;
		end
		return o;
	endfunction

endpackage

`default_nettype wire

@@ hdl/owmb_div.sv @@
// ---------------------------------------------------------------------------
// owmb_div
// Four-stage pipelined restoring divider, two quotient bits per stage.
// Quotient is known to fit in eight bits (numerator below 256 * divisor).
// ---------------------------------------------------------------------------
`default_nettype none

module owmb_div (
	input  wire logic                             clk,
	input  wire logic [owmb_pkg::NUM_W-1:0]       num,
	input  wire logic [owmb_pkg::MAG_W-1:0]       den,
	output logic      [owmb_pkg::QUO_W-1:0]       quo
);

	owmb_pkg::div_step_t st1, st2, st3, st4;

	logic [owmb_pkg::NUM_W-1:0] rem_s1, rem_s2, rem_s3;
	logic [owmb_pkg::MAG_W-1:0] den_s1, den_s2, den_s3;
	logic [1:0]                 quo_s1;
	logic [3:0]                 quo_s2;
	logic [5:0]                 quo_s3;
	logic [7:0]                 quo_s4;

	always_comb begin
		st1 = owmb_pkg::div_step2(num, den, 7);
		st2 = owmb_pkg::div_step2(rem_s1, den_s1, 5);
		st3 = owmb_pkg::div_step2(rem_s2, den_s2, 3);
		st4 = owmb_pkg::div_step2(rem_s3, den_s3, 1);
	end

	always_ff @(posedge clk) begin
		rem_s1 <= st1.rem;
		den_s1 <= den;
		quo_s1 <= st1.q;
		rem_s2 <= st2.rem;
		den_s2 <= den_s1;
		quo_s2 <= {quo_s1, st2.q};
		rem_s3 <= st3.rem;
		den_s3 <= den_s2;
		quo_s3 <= {quo_s2, st3.q};
		quo_s4 <= {quo_s3, st4.q};
	end

	assign quo = quo_s4;

endmodule

`default_nettype wire

@@ hdl/omni_wheel_mixer_bridge_drive.sv @@
// ---------------------------------------------------------------------------
// omni_wheel_mixer_bridge_drive
// Mixes a velocity command into four omni-wheel speeds, normalizes them to full
// scale when any exceeds it, clamps to the speed limit and maps to bridge duties.
// ---------------------------------------------------------------------------
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------
// command   | in        | start, busy          | vel_forward/sideways/rotate
// result    | out       | done (one cycle)     | four speeds, eight duties
// config    | in        | wr_en                | wr_index, wr_data
//
// A request is taken in every cycle; busy is always low.
// Each result passes through seven register stages: mix, magnitude/max,
// four divider stages, clamp and duty mapping.
// Reset clears the valid bits and loads decay_mode 0 and speed_limit 255.
// The result side cannot stall, so the pipeline never holds.
// ---------------------------------------------------------------------------
`default_nettype none

module omni_wheel_mixer_bridge_drive (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [owmb_pkg::VEL_W-1:0]    vel_forward,
	input  wire logic signed [owmb_pkg::VEL_W-1:0]    vel_sideways,
	input  wire logic signed [owmb_pkg::VEL_W-1:0]    vel_rotate,
	input  wire logic                                 wr_en,
	input  wire logic [owmb_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [owmb_pkg::CFG_DATA_W-1:0]      wr_data,
	output logic                                      done,
	output logic signed [owmb_pkg::SPEED_W-1:0]       front_left_speed,
	output logic signed [owmb_pkg::SPEED_W-1:0]       front_right_speed,
	output logic signed [owmb_pkg::SPEED_W-1:0]       rear_right_speed,
	output logic signed [owmb_pkg::SPEED_W-1:0]       rear_left_speed,
	output logic [owmb_pkg::DUTY_W-1:0]               front_left_dir_duty,
	output logic [owmb_pkg::DUTY_W-1:0]               front_left_pwm_duty,
	output logic [owmb_pkg::DUTY_W-1:0]               front_right_dir_duty,
	output logic [owmb_pkg::DUTY_W-1:0]               front_right_pwm_duty,
	output logic [owmb_pkg::DUTY_W-1:0]               rear_right_dir_duty,
	output logic [owmb_pkg::DUTY_W-1:0]               rear_right_pwm_duty,
	output logic [owmb_pkg::DUTY_W-1:0]               rear_left_dir_duty,
	output logic [owmb_pkg::DUTY_W-1:0]               rear_left_pwm_duty
);

	localparam int W = owmb_pkg::WHEELS;

	logic                                 decay_mode_q;
	logic [owmb_pkg::DUTY_W-1:0]          speed_limit_q;

	logic                                 accept;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	owmb_pkg::wheel_t                     w_s1 [W];

	logic [owmb_pkg::MAG_W-1:0]           mag_c [W];
	logic [owmb_pkg::MAG_W-1:0]           max_a, max_b, max_c;
	logic [owmb_pkg::NUM_W-1:0]           num_s2 [W];
	logic [owmb_pkg::MAG_W-1:0]           den_s2;
	logic                                 norm_s2, norm_s3, norm_s4, norm_s5, norm_s6;
	logic [W-1:0]                         neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	owmb_pkg::speed_t                     raw_s2 [W];
	owmb_pkg::speed_t                     raw_s3 [W];
	owmb_pkg::speed_t                     raw_s4 [W];
	owmb_pkg::speed_t                     raw_s5 [W];
	owmb_pkg::speed_t                     raw_s6 [W];

	logic [owmb_pkg::QUO_W-1:0]           quo [W];
	owmb_pkg::speed_t                     spd_c [W];
	owmb_pkg::speed_t                     speed_s7 [W];
	owmb_pkg::duty_t                      duty_s7 [W];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_mode_q  <= 1'b0;
			speed_limit_q <= owmb_pkg::DUTY_FULL;
		end else if (wr_en) begin
			unique case (wr_index)
				owmb_pkg::REG_DECAY_MODE:  decay_mode_q  <= wr_data[0];
				owmb_pkg::REG_SPEED_LIMIT: speed_limit_q <= wr_data;
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stage 1: mix
	always_ff @(posedge clk) begin
		if (accept) begin
			w_s1[owmb_pkg::FL] <= owmb_pkg::WHEEL_W'(vel_forward) + owmb_pkg::WHEEL_W'(vel_sideways)
				+ owmb_pkg::WHEEL_W'(vel_rotate);
			w_s1[owmb_pkg::FR] <= owmb_pkg::WHEEL_W'(vel_forward) - owmb_pkg::WHEEL_W'(vel_sideways)
				- owmb_pkg::WHEEL_W'(vel_rotate);
			w_s1[owmb_pkg::RR] <= owmb_pkg::WHEEL_W'(vel_forward) + owmb_pkg::WHEEL_W'(vel_sideways)
				- owmb_pkg::WHEEL_W'(vel_rotate);
			w_s1[owmb_pkg::RL] <= owmb_pkg::WHEEL_W'(vel_forward) - owmb_pkg::WHEEL_W'(vel_sideways)
				+ owmb_pkg::WHEEL_W'(vel_rotate);
		end
	end

	// stage 2: magnitudes, largest magnitude, scaled numerators
	always_comb begin
		for (int i = 0; i < W; i++) begin
			mag_c[i] = w_s1[i][owmb_pkg::WHEEL_W-1] ? owmb_pkg::MAG_W'(-w_s1[i])
				: w_s1[i][owmb_pkg::MAG_W-1:0];
		end
		max_a = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
		max_b = (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
		max_c = (max_a > max_b) ? max_a : max_b;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < W; i++) begin
			num_s2[i] <= (owmb_pkg::NUM_W'(mag_c[i]) << owmb_pkg::DUTY_W)
				- owmb_pkg::NUM_W'(mag_c[i]);
			neg_s2[i] <= w_s1[i][owmb_pkg::WHEEL_W-1];
			raw_s2[i] <= w_s1[i][owmb_pkg::SPEED_W-1:0];
		end
		den_s2  <= max_c;
		norm_s2 <= max_c > owmb_pkg::NORM_LIMIT;
	end

	// stages 3 to 6: dividers, with sign and raw speed carried alongside
	for (genvar g = 0; g < W; g++) begin : g_div
		owmb_div u_div (
			.clk (clk),
			.num (num_s2[g]),
			.den (den_s2),
			.quo (quo[g])
		);
	end

	always_ff @(posedge clk) begin
		norm_s3 <= norm_s2;
		norm_s4 <= norm_s3;
		norm_s5 <= norm_s4;
		norm_s6 <= norm_s5;
		neg_s3  <= neg_s2;
		neg_s4  <= neg_s3;
		neg_s5  <= neg_s4;
		neg_s6  <= neg_s5;
		raw_s3  <= raw_s2;
		raw_s4  <= raw_s3;
		raw_s5  <= raw_s4;
		raw_s6  <= raw_s5;
	end

	// stage 7: pick scaled or raw speed, clamp, map to duties
	always_comb begin
		for (int i = 0; i < W; i++) begin
			if (norm_s6) begin
				spd_c[i] = neg_s6[i] ? -owmb_pkg::SPEED_W'(quo[i]) : owmb_pkg::SPEED_W'(quo[i]);
			end else begin
				spd_c[i] = raw_s6[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < W; i++) begin
			speed_s7[i] <= spd_c[i];
			duty_s7[i]  <= owmb_pkg::bridge_map(spd_c[i], speed_limit_q, decay_mode_q);
		end
	end

	assign done                 = valid_s7;
	assign front_left_speed     = speed_s7[owmb_pkg::FL];
	assign front_right_speed    = speed_s7[owmb_pkg::FR];
	assign rear_right_speed     = speed_s7[owmb_pkg::RR];
	assign rear_left_speed      = speed_s7[owmb_pkg::RL];
	assign front_left_dir_duty  = duty_s7[owmb_pkg::FL].dir;
	assign front_left_pwm_duty  = duty_s7[owmb_pkg::FL].pwm;
	assign front_right_dir_duty = duty_s7[owmb_pkg::FR].dir;
	assign front_right_pwm_duty = duty_s7[owmb_pkg::FR].pwm;
	assign rear_right_dir_duty  = duty_s7[owmb_pkg::RR].dir;
	assign rear_right_pwm_duty  = duty_s7[owmb_pkg::RR].pwm;
	assign rear_left_dir_duty   = duty_s7[owmb_pkg::RL].dir;
	assign rear_left_pwm_duty   = duty_s7[owmb_pkg::RL].pwm;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 7))
		else $error("result without a request seven cycles earlier");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_left_speed != -9'sd256) && (front_right_speed != -9'sd256)
			&& (rear_right_speed != -9'sd256) && (rear_left_speed != -9'sd256))
		else $error("normalized speed out of range");

	a_zero_fl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && front_left_speed == '0) |->
			(front_left_dir_duty == '0) && (front_left_pwm_duty == '0))
		else $error("front-left zero speed with nonzero duty");

	a_zero_rr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rear_right_speed == '0) |->
			(rear_right_dir_duty == '0) && (rear_right_pwm_duty == '0))
		else $error("rear-right zero speed with nonzero duty");
`endif

endmodule

`default_nettype wire
